### rtl/msod_pkg.sv
`timescale 1ns / 1ps

package msod_pkg;

   // Slot array and counter sizing
   localparam int SLOT_COUNT  = 4;
   localparam int AGE_WIDTH   = 16;
   localparam int DEB_WIDTH   = 16;
   localparam int CMP_WIDTH   = (AGE_WIDTH > DEB_WIDTH) ? AGE_WIDTH : DEB_WIDTH;
   localparam int SLOT_WIDTH  = 2;
   localparam int FREE_WIDTH  = 3;
   localparam int COUNT_WIDTH = $clog2(SLOT_COUNT + 1) + 1;

   // Beat layout
   localparam int MODE_WIDTH     = 3;
   localparam int PERM_WIDTH     = 2;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_SELECT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUTTON_TEST    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS = 2'd2;
   localparam logic [DEB_WIDTH-1:0]       DEBOUNCE_RESET     = 16'd50;

   // Source select values
   localparam logic SOURCE_MANUAL = 1'b0;

   // Gate permission codes (zero and three act as none)
   localparam logic [PERM_WIDTH-1:0] PERM_ENTRY = 2'd1;
   localparam logic [PERM_WIDTH-1:0] PERM_EXIT  = 2'd2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TICK    = 3'd0,
      MODE_TOGGLE  = 3'd1,
      MODE_LOAD    = 3'd2,
      MODE_RESTORE = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   // One accepted request beat
   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [SLOT_COUNT-1:0] sensor_bits;
      logic [SLOT_COUNT-1:0] button_bits;
      logic [PERM_WIDTH-1:0] permission;
      logic [SLOT_WIDTH-1:0] slot_number;
      logic [SLOT_COUNT-1:0] occupancy_mask;
   } req_item_type;

   // Controls shared by every slot
   typedef struct packed {
      logic                  step;
      logic [MODE_WIDTH-1:0] mode;
      logic                  manual;
      logic                  button_test;
      logic [DEB_WIDTH-1:0]  debounce_ticks;
      logic [PERM_WIDTH-1:0] permission;
   } slot_ctl_type;

   // Per slot update results
   typedef struct packed {
      logic raw_next;
      logic stable_next;
      logic change_hit;
   } slot_status_type;

endpackage

### rtl/msod_slot.sv
`timescale 1ns / 1ps

module msod_slot (
   input  logic                     clock,
   input  logic                     reset,
   input  msod_pkg::slot_ctl_type   ctl,
   input  logic                     sensor_bit,
   input  logic                     button_bit,
   input  logic                     toggle_hit,
   input  logic                     occ_bit,
   output msod_pkg::slot_status_type status
);
   import msod_pkg::*;

   logic                 raw_ff, raw_in;
   logic                 stable_ff, stable_in;
   logic                 virt_ff, virt_in;
   logic                 btn_raw_ff, btn_raw_in;
   logic                 btn_stable_ff, btn_stable_in;
   logic [AGE_WIDTH-1:0] raw_age_ff, raw_age_in;
   logic [AGE_WIDTH-1:0] btn_age_ff, btn_age_in;
   logic                 change_hit;

   logic [AGE_WIDTH-1:0] raw_age_inc;
   logic [AGE_WIDTH-1:0] btn_age_inc;
   logic                 raw_held;
   logic                 btn_held;
   logic                 sample;

   // Saturating age counters and debounce threshold compares
   assign raw_age_inc = (raw_age_ff == '1) ? raw_age_ff : raw_age_ff + 1'b1;
   assign btn_age_inc = (btn_age_ff == '1) ? btn_age_ff : btn_age_ff + 1'b1;
   assign raw_held = CMP_WIDTH'(raw_age_inc) >= CMP_WIDTH'(ctl.debounce_ticks);
   assign btn_held = CMP_WIDTH'(btn_age_inc) >= CMP_WIDTH'(ctl.debounce_ticks);
   assign sample   = ctl.manual ? virt_ff : sensor_bit;

   // Next state of the slot for the current beat
   always_comb begin
      raw_in        = raw_ff;
      stable_in     = stable_ff;
      virt_in       = virt_ff;
      btn_raw_in    = btn_raw_ff;
      btn_stable_in = btn_stable_ff;
      raw_age_in    = raw_age_ff;
      btn_age_in    = btn_age_ff;
      change_hit    = 1'b0;
      unique case (ctl.mode)
         MODE_TICK: begin
            raw_age_in = raw_age_inc;
            btn_age_in = btn_age_inc;
            if (ctl.manual && ctl.button_test) begin
               // gated button path
               if (button_bit != btn_raw_ff) begin
                  btn_raw_in = button_bit;
                  btn_age_in = '0;
               end else if (button_bit != btn_stable_ff && btn_held) begin
                  btn_stable_in = button_bit;
                  if (button_bit) begin
                     if (ctl.permission == PERM_ENTRY && !virt_ff) begin
                        virt_in    = 1'b1;
                        raw_in     = 1'b1;
                        stable_in  = 1'b1;
                        change_hit = 1'b1;
                     end else if (ctl.permission == PERM_EXIT && virt_ff) begin
                        virt_in    = 1'b0;
                        raw_in     = 1'b0;
                        stable_in  = 1'b0;
                        change_hit = 1'b1;
                     end
                  end
               end
            end else begin
               // occupancy sample path
               if (sample != raw_ff) begin
                  raw_in     = sample;
                  raw_age_in = '0;
               end else if (sample != stable_ff && raw_held) begin
                  stable_in  = sample;
                  change_hit = 1'b1;
               end
            end
         end
         MODE_TOGGLE: begin
            if (ctl.manual && toggle_hit) begin
               virt_in = !virt_ff;
            end
         end
         MODE_LOAD: begin
            if (ctl.manual) begin
               virt_in = occ_bit;
            end
         end
         MODE_RESTORE: begin
            raw_in        = occ_bit;
            stable_in     = occ_bit;
            virt_in       = occ_bit;
            btn_raw_in    = occ_bit;
            btn_stable_in = occ_bit;
            raw_age_in    = '0;
            btn_age_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // Slot state registers, advanced once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff        <= 1'b0;
         stable_ff     <= 1'b0;
         virt_ff       <= 1'b0;
         btn_raw_ff    <= 1'b0;
         btn_stable_ff <= 1'b0;
         raw_age_ff    <= '0;
         btn_age_ff    <= '0;
      end else if (ctl.step) begin
         raw_ff        <= raw_in;
         stable_ff     <= stable_in;
         virt_ff       <= virt_in;
         btn_raw_ff    <= btn_raw_in;
         btn_stable_ff <= btn_stable_in;
         raw_age_ff    <= raw_age_in;
         btn_age_ff    <= btn_age_in;
      end
   end

   assign status.raw_next    = raw_in;
   assign status.stable_next = stable_in;
   assign status.change_hit  = change_hit;

endmodule

### rtl/multi_slot_occupancy_debouncer_core.sv
`timescale 1ns / 1ps
// Path: a request beat is registered on acceptance and its response is registered
// once the beat advances, which a stalled output holds off. Throughput: one beat
// per cycle unless stalled; all slots update side by side in one pass.
// Reset: synchronous, active high; slots empty, ages zero, change flag set,
// debounce threshold 50, manual source, button test off.

module multi_slot_occupancy_debouncer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: sensor_bits[3:0], button_bits[7:4], permission[9:8],
   //        slot_number[11:10], occupancy_mask[15:12]
   input  logic [msod_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // tuser: mode[2:0]
   input  logic [msod_pkg::MODE_WIDTH-1:0]       req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: stable_mask[3:0], raw_mask[7:4], free_slots[10:8],
   //        all_full[11], change_flag[12], zero fill[15:13]
   output logic [msod_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [msod_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [msod_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import msod_pkg::*;

   logic                  source_ff;
   logic                  button_test_ff;
   logic [DEB_WIDTH-1:0]  debounce_ff;

   logic                  in_valid_ff;
   req_item_type          in_item_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  changed_ff, changed_in;

   logic                  advance;
   req_item_type          req_item;
   slot_ctl_type          ctl;
   slot_status_type [SLOT_COUNT-1:0] status;
   logic [SLOT_COUNT-1:0] stable_next;
   logic [SLOT_COUNT-1:0] raw_next;
   logic [SLOT_COUNT-1:0] change_hits;
   logic [COUNT_WIDTH-1:0] free_n;
   logic [FREE_WIDTH-1:0] free_slots;

   // Handshake: the input register refills when empty or whenever its beat moves on
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Unpack the request beat
   assign req_item.mode           = req_tuser;
   assign req_item.sensor_bits    = req_tdata[3:0];
   assign req_item.button_bits    = req_tdata[7:4];
   assign req_item.permission     = req_tdata[9:8];
   assign req_item.slot_number    = req_tdata[11:10];
   assign req_item.occupancy_mask = req_tdata[15:12];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff      <= SOURCE_MANUAL;
         button_test_ff <= 1'b0;
         debounce_ff    <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_SELECT:  source_ff      <= csr_wdata[0];
            CSR_BUTTON_TEST:    button_test_ff <= csr_wdata[0];
            CSR_DEBOUNCE_TICKS: debounce_ff    <= csr_wdata[DEB_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   // Controls shared by the slots
   assign ctl.step           = advance;
   assign ctl.mode           = in_item_ff.mode;
   assign ctl.manual         = (source_ff == SOURCE_MANUAL);
   assign ctl.button_test    = button_test_ff;
   assign ctl.debounce_ticks = debounce_ff;
   assign ctl.permission     = in_item_ff.permission;

   // Per slot state and update logic
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      msod_slot u_slot (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .sensor_bit (in_item_ff.sensor_bits[i]),
         .button_bit (in_item_ff.button_bits[i]),
         .toggle_hit (in_item_ff.slot_number == SLOT_WIDTH'(i)),
         .occ_bit    (in_item_ff.occupancy_mask[i]),
         .status     (status[i])
      );
      assign stable_next[i] = status[i].stable_next;
      assign raw_next[i]    = status[i].raw_next;
      assign change_hits[i] = status[i].change_hit;
   end

   // Sticky change flag
   always_comb begin
      changed_in = changed_ff;
      case (in_item_ff.mode)
         MODE_TICK:                  changed_in = changed_ff | (|change_hits);
         MODE_RESTORE, MODE_CLEAR:   changed_in = 1'b0;
         default:                    changed_in = changed_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         changed_ff <= 1'b1;
      end else if (advance) begin
         changed_ff <= changed_in;
      end
   end

   // Free slot count over the updated stable mask
   always_comb begin
      free_n = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         free_n = free_n + COUNT_WIDTH'(!stable_next[i]);
      end
   end
   assign free_slots = free_n[FREE_WIDTH-1:0];

   // Response beat packing
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[3:0]   = stable_next;
      rsp_data_in[7:4]   = raw_next;
      rsp_data_in[10:8]  = free_slots;
      rsp_data_in[11]    = (free_n == '0);
      rsp_data_in[12]    = changed_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   a_free_matches_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff[10:8]) + 32'($countones(rsp_data_ff[3:0]))
                        == 32'(SLOT_COUNT)))
      else $error("free count disagrees with stable mask");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[11] == (rsp_data_ff[10:8] == '0)))
      else $error("full flag disagrees with free count");

   a_restore_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_item_ff.mode == MODE_RESTORE || in_item_ff.mode == MODE_CLEAR))
      |=> (rsp_valid_ff && !rsp_data_ff[12]))
      else $error("change flag not cleared");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready && in_valid_ff))
      else $error("request side stalled without output back pressure");

endmodule

### tb/sv/multi_slot_occupancy_debouncer_core_tb.sv
`timescale 1ns / 1ps

module multi_slot_occupancy_debouncer_core_tb;
   import msod_pkg::*;

   localparam logic SOURCE_SENSOR = ~SOURCE_MANUAL;

   // Response beat, last field in the lowest bits
   typedef struct packed {
      logic                  change_flag;
      logic                  all_full;
      logic [FREE_WIDTH-1:0] free_slots;
      logic [SLOT_COUNT-1:0] raw_mask;
      logic [SLOT_COUNT-1:0] stable_mask;
   } occ_report_type;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata  = '0;
   logic [MODE_WIDTH-1:0]      req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   multi_slot_occupancy_debouncer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predicted slot state and register copies
   logic                  cfg_source;
   logic                  cfg_buttons;
   logic [DEB_WIDTH-1:0]  cfg_ticks;
   logic [SLOT_COUNT-1:0] occ_raw, occ_stable, occ_virtual;
   logic [SLOT_COUNT-1:0] btn_raw, btn_stable;
   logic [AGE_WIDTH-1:0]  occ_age [SLOT_COUNT];
   logic [AGE_WIDTH-1:0]  btn_age [SLOT_COUNT];
   logic                  change_seen;

   req_item_type   queued_beats[$];
   occ_report_type due_reports[$];
   req_item_type   held_beat;
   logic         item_held  = 1'b0;
   int           gap_left   = 0;
   int           stall_left = 0;
   int           beats_sent = 0;
   int           error_count = 0;
   logic         steady     = 1'b0;
   logic         hold_rsp   = 1'b0;

   task automatic clear_model();
      cfg_source  = SOURCE_MANUAL;
      cfg_buttons = 1'b0;
      cfg_ticks   = DEBOUNCE_RESET;
      occ_raw     = '0;
      occ_stable  = '0;
      occ_virtual = '0;
      btn_raw     = '0;
      btn_stable  = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         occ_age[i] = '0;
         btn_age[i] = '0;
      end
      change_seen = 1'b1;
   endtask

   // Apply one request beat to the predicted state and build its report
   function automatic occ_report_type step_occupancy(input req_item_type it);
      occ_report_type r;
      logic        manual;
      logic        sample;
      logic        took;
      int          free_n;
      manual = (cfg_source == SOURCE_MANUAL);
      case (it.mode)
         MODE_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (occ_age[i] != '1) occ_age[i]++;
               if (btn_age[i] != '1) btn_age[i]++;
            end
            if (manual && cfg_buttons) begin
               // buttons drive the virtual slots, sensor path skipped
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (it.button_bits[i] != btn_raw[i]) begin
                     btn_raw[i] = it.button_bits[i];
                     btn_age[i] = '0;
                  end else if (it.button_bits[i] != btn_stable[i] &&
                               btn_age[i] >= cfg_ticks) begin
                     btn_stable[i] = it.button_bits[i];
                     took = 1'b0;
                     if (it.button_bits[i]) begin
                        if (it.permission == PERM_ENTRY && !occ_virtual[i]) begin
                           occ_virtual[i] = 1'b1;
                           took = 1'b1;
                        end else if (it.permission == PERM_EXIT && occ_virtual[i]) begin
                           occ_virtual[i] = 1'b0;
                           took = 1'b1;
                        end
                     end
                     if (took) begin
                        occ_stable[i] = occ_virtual[i];
                        occ_raw[i]    = occ_virtual[i];
                        change_seen   = 1'b1;
                     end
                  end
               end
            end else begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  sample = manual ? occ_virtual[i] : it.sensor_bits[i];
                  if (sample != occ_raw[i]) begin
                     occ_raw[i] = sample;
                     occ_age[i] = '0;
                  end else if (sample != occ_stable[i] && occ_age[i] >= cfg_ticks) begin
                     occ_stable[i] = sample;
                     change_seen   = 1'b1;
                  end
               end
            end
         end
         MODE_TOGGLE: begin
            if (manual && it.slot_number < SLOT_COUNT)
               occ_virtual[it.slot_number] = ~occ_virtual[it.slot_number];
         end
         MODE_LOAD: begin
            if (manual) occ_virtual = it.occupancy_mask;
         end
         MODE_RESTORE: begin
            occ_raw     = it.occupancy_mask;
            occ_stable  = it.occupancy_mask;
            occ_virtual = it.occupancy_mask;
            btn_raw     = it.occupancy_mask;
            btn_stable  = it.occupancy_mask;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               occ_age[i] = '0;
               btn_age[i] = '0;
            end
            change_seen = 1'b0;
         end
         MODE_CLEAR: change_seen = 1'b0;
         default: ;
      endcase
      free_n = 0;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (!occ_stable[i]) free_n++;
      r.stable_mask = occ_stable;
      r.raw_mask    = occ_raw;
      r.free_slots  = FREE_WIDTH'(free_n);
      r.all_full    = (free_n == 0);
      r.change_flag = change_seen;
      return r;
   endfunction

   function automatic int wait_draw();
      return steady ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic flag_error(input string why, input occ_report_type want,
                             input occ_report_type seen);
      error_count++;
      if (error_count <= 10)
         $display({"%0t %0s: expected stable %h raw %h free %0d full %b chg %b,",
                   " got stable %h raw %h free %0d full %b chg %b"},
                  $realtime, why, want.stable_mask, want.raw_mask, want.free_slots,
                  want.all_full, want.change_flag, seen.stable_mask, seen.raw_mask,
                  seen.free_slots, seen.all_full, seen.change_flag);
   endtask

   // Request driver: one beat held at a time, random gap after each unless steady
   always @(posedge clock) begin
      logic fire;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (fire) begin
            due_reports.push_back(step_occupancy(held_beat));
            beats_sent++;
            item_held = 1'b0;
         end
         if (!item_held) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_beats.size() > 0) begin
               held_beat = queued_beats.pop_front();
               req_tdata <= {held_beat.occupancy_mask, held_beat.slot_number,
                             held_beat.permission, held_beat.button_bits,
                             held_beat.sensor_bits};
               req_tuser <= held_beat.mode;
               item_held = 1'b1;
               gap_left  = wait_draw();
            end
         end
         req_tvalid <= item_held;
      end
   end

   // Response monitor: check each beat, then stall at random unless steady or held off
   always @(posedge clock) begin
      occ_report_type seen;
      occ_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(occ_report_type)-1:0];
            if (due_reports.size() == 0) begin
               flag_error("unexpected beat", '0, seen);
            end else begin
               want = due_reports.pop_front();
               if (seen.stable_mask !== want.stable_mask || seen.raw_mask !== want.raw_mask ||
                   seen.free_slots !== want.free_slots || seen.all_full !== want.all_full ||
                   seen.change_flag !== want.change_flag)
                  flag_error("mismatch", want, seen);
            end
            stall_left = wait_draw();
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input
   initial begin
      while (beats_sent < 150) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_item_type any_item(input logic [MODE_WIDTH-1:0] m);
      req_item_type it;
      it.mode           = m;
      it.sensor_bits    = SLOT_COUNT'($urandom);
      it.button_bits    = SLOT_COUNT'($urandom);
      it.permission     = PERM_WIDTH'($urandom);
      it.slot_number    = SLOT_WIDTH'($urandom);
      it.occupancy_mask = SLOT_COUNT'($urandom);
      return it;
   endfunction

   task automatic push_beat(input mode_type m, input logic [SLOT_COUNT-1:0] sens,
                            input logic [SLOT_COUNT-1:0] btn, input logic [PERM_WIDTH-1:0] perm,
                            input logic [SLOT_WIDTH-1:0] slot,
                            input logic [SLOT_COUNT-1:0] occ);
      req_item_type it;
      it.mode           = m;
      it.sensor_bits    = sens;
      it.button_bits    = btn;
      it.permission     = perm;
      it.slot_number    = slot;
      it.occupancy_mask = occ;
      queued_beats.push_back(it);
   endtask

   // Runs of held sensor and button levels with the odd glitch, plus stray commands
   task automatic push_traffic(input int n, input int max_hold);
      req_item_type          it;
      logic [SLOT_COUNT-1:0] lvl_s, lvl_b;
      logic [PERM_WIDTH-1:0] perm;
      int                    pushed, run_len;
      pushed = 0;
      while (pushed < n) begin
         if ($urandom_range(0, 7) == 0) begin
            queued_beats.push_back(any_item(MODE_WIDTH'($urandom)));
            pushed++;
         end else begin
            lvl_s   = SLOT_COUNT'($urandom);
            lvl_b   = SLOT_COUNT'($urandom);
            perm    = PERM_WIDTH'($urandom);
            run_len = $urandom_range(1, max_hold);
            for (int k = 0; k < run_len; k++) begin
               it             = any_item(MODE_TICK);
               it.sensor_bits = lvl_s;
               it.button_bits = lvl_b;
               it.permission  = perm;
               if ($urandom_range(0, 15) == 0)
                  it.sensor_bits[$urandom_range(0, SLOT_COUNT-1)] ^= 1'b1;
               if ($urandom_range(0, 15) == 0)
                  it.button_bits[$urandom_range(0, SLOT_COUNT-1)] ^= 1'b1;
               queued_beats.push_back(it);
               pushed++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (queued_beats.size() != 0 || item_held || due_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges, block idle
   task automatic set_config(input logic src, input logic btn,
                             input logic [DEB_WIDTH-1:0] ticks);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE_SELECT;
      csr_wdata <= CSR_DATA_WIDTH'(src);
      @(posedge clock);
      csr_index <= CSR_BUTTON_TEST;
      csr_wdata <= CSR_DATA_WIDTH'(btn);
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE_TICKS;
      csr_wdata <= CSR_DATA_WIDTH'(ticks);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_source  = src;
      cfg_buttons = btn;
      cfg_ticks   = ticks;
   endtask

   initial begin
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Manual source, plain debounce of the virtual store
      set_config(SOURCE_MANUAL, 1'b0, DEB_WIDTH'(1));
      push_beat(MODE_TICK, '1, '1, '1, '1, '1);
      push_beat(MODE_CLEAR, '0, '0, '0, '0, '0);
      push_beat(MODE_LOAD, '0, '0, '0, '0, '1);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_TOGGLE, '0, '0, '0, '0, '0);
      push_beat(MODE_TOGGLE, '1, '1, '1, '1, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_RESTORE, '0, '0, '0, '0, SLOT_COUNT'(4'b1010));
      for (int m = int'(MODE_CLEAR) + 1; m < (1 << MODE_WIDTH); m++)
         queued_beats.push_back(any_item(MODE_WIDTH'(m)));

      // Sensor source: toggle and load do nothing
      set_config(SOURCE_SENSOR, 1'b0, '0);
      push_beat(MODE_TOGGLE, '0, '0, '0, SLOT_WIDTH'(1), '0);
      push_beat(MODE_LOAD, '0, '0, '0, '0, '1);
      push_beat(MODE_TICK, '1, '0, '0, '0, '0);
      push_beat(MODE_TICK, '1, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);

      // Gated buttons: entry sets, exit clears
      set_config(SOURCE_MANUAL, 1'b1, '0);
      push_beat(MODE_RESTORE, '0, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '1, PERM_ENTRY, '0, '0);
      push_beat(MODE_TICK, '0, '1, PERM_ENTRY, '0, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '0, '0, '0, '0);
      push_beat(MODE_TICK, '0, '1, PERM_EXIT, '0, '0);
      push_beat(MODE_TICK, '0, '1, PERM_EXIT, '0, '0);

      // Random traffic across several settings, idling on and off
      set_config(SOURCE_MANUAL, 1'b0, DEB_WIDTH'(2));
      steady <= 1'b0;
      push_traffic(250, 6);
      set_config(SOURCE_SENSOR, 1'b0, DEB_WIDTH'(3));
      steady <= 1'b1;
      push_traffic(250, 8);
      set_config(SOURCE_MANUAL, 1'b1, DEB_WIDTH'(1));
      steady <= 1'b0;
      push_traffic(200, 5);
      set_config(SOURCE_SENSOR, 1'b1, DEB_WIDTH'(5));
      steady <= 1'b0;
      push_traffic(200, 10);
      set_config(SOURCE_MANUAL, 1'b1, DEB_WIDTH'(3));
      steady <= 1'b1;
      push_traffic(200, 8);
      set_config(SOURCE_SENSOR, 1'b0, DEBOUNCE_RESET);
      steady <= 1'b0;
      push_traffic(100, 60);

      // Largest threshold: a short held level never becomes stable
      set_config(SOURCE_SENSOR, 1'b1, '1);
      steady <= 1'b1;
      push_beat(MODE_RESTORE, '0, '0, '0, '0, '0);
      for (int k = 0; k < 8; k++)
         push_beat(MODE_TICK, '1, '0, '0, '0, '0);
      for (int k = 0; k < 3; k++)
         push_beat(MODE_TICK, '0, '0, '0, '0, '0);

      wait_drained();
      if (error_count == 0 && due_reports.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/msod_pkg.sv
rtl/msod_slot.sv
rtl/multi_slot_occupancy_debouncer_core.sv
tb/sv/multi_slot_occupancy_debouncer_core_tb.sv
